// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the scanner core.
// MBPS_ASSERT checks while out of reset; MBPS_ASSERT_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MBPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define MBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MBPS_ASSERT(lbl, clk, rstn, prop, msg)

`define MBPS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/mbps_pkg.sv =====
`default_nettype none

package mbps_pkg;

  localparam int NUM_CELLS  = 16;  // window depth / max pattern bytes
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = $clog2(NUM_CELLS + 1);
  localparam int POS_W      = $clog2(NUM_CELLS);
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VAL_LO = 3'd0,
    REG_VAL_HI = 3'd1,
    REG_MSK_LO = 3'd2,
    REG_MSK_HI = 3'd3,
    REG_LEN    = 3'd4
  } reg_idx_e;

  // pattern byte aligned to one window cell
  typedef struct packed {
    logic              in_use;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] mask;
  } cell_pat_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             len_ok;
  } pat_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbps_if.sv =====
`default_nettype none

interface mbps_item_if;
  logic                        valid;
  logic                        ready;
  logic [mbps_pkg::BYTE_W-1:0] data_byte;
  logic [mbps_pkg::ADDR_W-1:0] byte_address;
  logic                        restart;

  modport source (output valid, data_byte, byte_address, restart, input ready);
  modport sink   (input valid, data_byte, byte_address, restart, output ready);
endinterface

interface mbps_result_if;
  logic                        valid;
  logic                        ready;
  logic                        match_found;
  logic [mbps_pkg::ADDR_W-1:0] match_address;

  modport source (output valid, match_found, match_address, input ready);
  modport sink   (input valid, match_found, match_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/masked_byte_pattern_scanner_core.sv =====
//  channel   dir  handshake      payload
//  item_i    in   valid/ready    data_byte[7:0], byte_address[47:0], restart
//  result_o  out  valid/ready    match_found, match_address[47:0]
//  cfg       in   cfg_we_i       cfg_idx_i[2:0], cfg_wdata_i[63:0]
//
//  One byte per cycle while the result side keeps ready high; a result is presented the cycle after its transfer.
//  The window is a row of 16 cells; each compares the byte it is about to take.
//  Input stays ready while the output register is empty or being drained.
//  Reset clears the config registers, cell valid bits and the output valid.
//  No clearing pass: restart just drops the cell valid bits.
`default_nettype none

module masked_byte_pattern_scanner_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mbps_item_if.sink                       item_i,
  mbps_result_if.source                   result_o
);
  import mbps_pkg::*;

`include "assert_macros.svh"

  cell_pat_t [NUM_CELLS-1:0] cell_pat;
  pat_ctl_t                  pat_ctl;

  logic                             accept;
  logic [NUM_CELLS-1:0][BYTE_W-1:0] cell_byte;    // stored window, 0 newest
  logic [NUM_CELLS-1:0]             cell_vld;
  logic [NUM_CELLS-1:0][BYTE_W-1:0] chain_byte;   // byte handed into each cell
  logic [NUM_CELLS-1:0]             chain_vld;
  logic [NUM_CELLS-1:0]             cell_hit;
  logic                             hit;
  logic [NUM_CELLS-1:0]             vld_gap;

  logic              out_vld_d, out_vld_q;
  logic              found_q;
  logic [ADDR_W-1:0] addr_q;

  // pattern registers, already lined up per cell
  mbps_pattern u_pattern (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cell_pat_o  (cell_pat),
    .ctl_o       (pat_ctl)
  );

  // skid-free pipe: take a byte whenever the result slot frees up this cycle
  assign item_i.ready = !out_vld_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  // window chain; restart knocks out every older byte on the way in
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_byte[i] = item_i.data_byte;
      assign chain_vld[i]  = 1'b1;
    end else begin : g_body
      assign chain_byte[i] = cell_byte[i-1];
      assign chain_vld[i]  = cell_vld[i-1] && !item_i.restart;
    end

    mbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .byte_i  (chain_byte[i]),
      .vld_i   (chain_vld[i]),
      .pat_i   (cell_pat[i]),
      .byte_o  (cell_byte[i]),
      .vld_o   (cell_vld[i]),
      .hit_o   (cell_hit[i])
    );
  end

  // unused cells report a hit, so the AND only sees the live span;
  // the cell at len-1 being valid covers the short-window case
  assign hit = pat_ctl.len_ok && (&cell_hit);

  always_comb begin
    out_vld_d = out_vld_q;
    if (accept) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // start address = end address - (len - 1), wraps mod 2^ADDR_W
  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q <= hit;
      addr_q  <= hit ? (item_i.byte_address - ADDR_W'(pat_ctl.len) + ADDR_W'(1)) : '0;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.match_found   = found_q;
  assign result_o.match_address = addr_q;

  // valid bits must stay a thermometer from the newest cell
  assign vld_gap = cell_vld & ~{cell_vld[NUM_CELLS-2:0], 1'b1};

  `MBPS_ASSERT(a_restart_one_valid, clk_i, rst_ni, accept && item_i.restart |=> $countones(cell_vld) == 1, "restart left stale window bytes")
  `MBPS_ASSERT(a_vld_thermo, clk_i, rst_ni, vld_gap == '0, "window valid bits not contiguous")
  `MBPS_ASSERT(a_hit_len_ok, clk_i, rst_ni, result_o.valid && result_o.match_found |-> pat_ctl.len_ok, "match with disabled pattern length")
  `MBPS_ASSERT(a_miss_addr_zero, clk_i, rst_ni, result_o.valid && !result_o.match_found |-> result_o.match_address == '0, "nonzero address on miss")
  `MBPS_ASSERT(a_accept_loads, clk_i, rst_ni, accept |=> result_o.valid, "transfer produced no result")
  `MBPS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !result_o.valid, "result valid out of reset")

endmodule

`default_nettype wire

// ===== rtl/core/mbps_cell.sv =====
`default_nettype none

module mbps_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [mbps_pkg::BYTE_W-1:0] byte_i,
  input  logic                        vld_i,
  input  mbps_pkg::cell_pat_t         pat_i,
  output logic [mbps_pkg::BYTE_W-1:0] byte_o,
  output logic                        vld_o,
  output logic                        hit_o
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic              vld_q;

  // compare on the byte entering this cell (post-shift window)
  always_comb begin
    hit_o = !pat_i.in_use || (vld_i && ((byte_i & pat_i.mask) == pat_i.value));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;

endmodule

`default_nettype wire

// ===== rtl/core/mbps_pattern.sv =====
`default_nettype none

module mbps_pattern (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output mbps_pkg::cell_pat_t [mbps_pkg::NUM_CELLS-1:0] cell_pat_o,
  output mbps_pkg::pat_ctl_t              ctl_o
);
  import mbps_pkg::*;

  logic [CFG_DATA_W-1:0] val_lo_q, val_hi_q, msk_lo_q, msk_hi_q;
  logic [LEN_W-1:0]      len_q;

  logic [NUM_CELLS-1:0][BYTE_W-1:0] val_row, msk_row;
  logic [POS_W-1:0]                 pidx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_lo_q <= '0;
      val_hi_q <= '0;
      msk_lo_q <= '0;
      msk_hi_q <= '0;
      len_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_VAL_LO: val_lo_q <= cfg_wdata_i;
        REG_VAL_HI: val_hi_q <= cfg_wdata_i;
        REG_MSK_LO: msk_lo_q <= cfg_wdata_i;
        REG_MSK_HI: msk_hi_q <= cfg_wdata_i;
        REG_LEN:    len_q    <= cfg_wdata_i[LEN_W-1:0];
        default:    ;  // unmapped index, dropped
      endcase
    end
  end

  assign val_row = {val_hi_q, val_lo_q};
  assign msk_row = {msk_hi_q, msk_lo_q};

  // cell i (0 = newest) lines up with pattern byte len-1-i
  always_comb begin
    pidx = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      pidx                 = POS_W'(len_q - LEN_W'(i) - LEN_W'(1));
      cell_pat_o[i].in_use = LEN_W'(i) < len_q;
      cell_pat_o[i].value  = val_row[pidx];
      cell_pat_o[i].mask   = msk_row[pidx];
    end
  end

  assign ctl_o.len    = len_q;
  assign ctl_o.len_ok = (len_q != '0) && (len_q <= LEN_W'(NUM_CELLS));

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mbps_pkg::*;

  // Indexes past the last real register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

  // Common compare masks: whole byte, low nibble only, high nibble only, wild.
  localparam bit [7:0] MASK_FULL = 8'hFF;
  localparam bit [7:0] MASK_LO_NIB = 8'h0F;
  localparam bit [7:0] MASK_HI_NIB = 8'hF0;
  localparam bit [7:0] MASK_WILD = 8'h00;

  localparam bit [ADDR_W-1:0] ADDR_TOP = '1;
  localparam int ERR_PRINT_CAP = 40;

  typedef struct {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  // Holds a copy of the pattern registers and the byte window, predicts the
  // result of every byte transfer and checks results in order.
  class scan_scoreboard;
    bit [63:0] val_lo = '0, val_hi = '0, msk_lo = '0, msk_hi = '0;
    bit [4:0] pat_len = '0;
    bit [7:0] window [NUM_CELLS];
    int unsigned fill = 0;
    scan_result_t expected_q[$];
    int unsigned errors = 0;
    int unsigned hits = 0;

    function bit [7:0] pat_value(int k);
      bit [127:0] w;
      w = {val_hi, val_lo};
      return w[k*8 +: 8];
    endfunction

    function bit [7:0] pat_mask(int k);
      bit [127:0] w;
      w = {msk_hi, msk_lo};
      return w[k*8 +: 8];
    endfunction

    function void take_write(logic [CFG_IDX_W-1:0] idx, bit [63:0] d);
      case (idx)
        REG_VAL_LO: val_lo = d;
        REG_VAL_HI: val_hi = d;
        REG_MSK_LO: msk_lo = d;
        REG_MSK_HI: msk_hi = d;
        REG_LEN:    pat_len = d[4:0];
        default: ;
      endcase
    endfunction

    function void note_item(bit [7:0] d, bit [ADDR_W-1:0] a, bit r);
      scan_result_t e;
      bit ok;
      if (r) begin
        foreach (window[k]) window[k] = '0;
        fill = 0;
      end
      for (int k = NUM_CELLS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = d;
      if (fill < NUM_CELLS) fill++;
      e.found = 1'b0;
      e.addr = '0;
      if (pat_len >= 1 && pat_len <= NUM_CELLS && fill >= pat_len) begin
        ok = 1'b1;
        // pattern byte 0 lines up with the oldest byte of the span
        for (int k = 0; k < pat_len; k++) begin
          if ((window[pat_len - 1 - k] & pat_mask(k)) != pat_value(k)) ok = 1'b0;
        end
        e.found = ok;
        if (ok) e.addr = a - (ADDR_W'(pat_len) - ADDR_W'(1));
      end
      expected_q.insert(expected_q.size(), e);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < ERR_PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic found, logic [ADDR_W-1:0] addr);
      scan_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result found=%b addr=%h with nothing expected",
                                  found, addr));
        return;
      end
      e = expected_q.pop_front();
      if (found !== e.found)
        report_mismatch($sformatf("match_found %b, expected %b", found, e.found));
      if (addr !== e.addr)
        report_mismatch($sformatf("match_address %h, expected %h", addr, e.addr));
      if (e.found) hits++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mbps_item_if item_ch ();
  mbps_result_if result_ch ();

  masked_byte_pattern_scanner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_ch),
    .result_o    (result_ch)
  );

  scan_scoreboard sb;

  bit steady = 1'b0;            // both sides stop idling while set
  bit restart_next = 1'b0;      // restart flag for the next emitted byte
  bit [ADDR_W-1:0] next_addr = '0;
  int unsigned sent = 0;
  int unsigned settings = 0;
  int unsigned restarts = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each transfer, then pick ready for the next edge.
  // Values are sampled at the edge before any nonblocking update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.match_found, result_ch.match_address);
      result_ch.ready <= steady || ($urandom_range(99) >= 10);
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("masked_byte_pattern_scanner_core: mismatch");
    $finish;
  end

  // One byte transfer. Valid is left high on return; the next call or a
  // drain decides whether it drops, so it is never lowered and raised in
  // the same step.
  task automatic send_byte(input bit [7:0] d, input bit [ADDR_W-1:0] a, input bit r);
    while (!steady && $urandom_range(99) < 10) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data_byte <= d;
    item_ch.byte_address <= a;
    item_ch.restart <= r;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    sb.note_item(d, a, r);
    sent++;
    if (r) restarts++;
  endtask

  // Next byte of the running stream; a few restarts come at random.
  task automatic emit(input bit [7:0] d);
    bit r;
    r = restart_next || ($urandom_range(99) < 2);
    restart_next = 1'b0;
    send_byte(d, next_addr, r);
    next_addr++;
  endtask

  // Hold the sender until every outstanding result has been seen.
  // Always waits on the clock before returning, so valid is driven once per step.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Write enable stays high on return so back-to-back writes don't toggle it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [63:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    sb.take_write(idx, d);
  endtask

  // Only while idle: drain first, then all five registers, then the spare indexes if asked.
  task automatic load_pattern(input bit [127:0] vals, input bit [127:0] masks,
                              input bit [63:0] len_word, input bit with_spares);
    wait_drained();
    write_reg(REG_VAL_LO, vals[63:0]);
    write_reg(REG_VAL_HI, vals[127:64]);
    write_reg(REG_MSK_LO, masks[63:0]);
    write_reg(REG_MSK_HI, masks[127:64]);
    write_reg(REG_LEN, len_word);
    if (with_spares) begin
      for (int s = REG_SPARE_FIRST; s < (1 << CFG_IDX_W); s++)
        write_reg(s[CFG_IDX_W-1:0], {$urandom, $urandom});
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic bit [ADDR_W-1:0] rand_addr();
    case ($urandom_range(3))
      0: return ADDR_W'($urandom_range(20));
      1: return ADDR_TOP - ADDR_W'($urandom_range(20));
      default: return ADDR_W'({$urandom, $urandom});
    endcase
  endfunction

  // Random pattern; force_len < 0 picks a length, weighted toward edges.
  task automatic random_pattern(input int force_len);
    bit [127:0] v, m;
    bit [63:0] lw;
    bit [7:0] mb;
    int len, r;
    for (int k = 0; k < NUM_CELLS; k++) begin
      case ($urandom_range(5))
        0, 1: mb = MASK_FULL;
        2: mb = MASK_LO_NIB;
        3: mb = MASK_HI_NIB;
        4: mb = MASK_WILD;
        default: mb = 8'($urandom);
      endcase
      m[k*8 +: 8] = mb;
      v[k*8 +: 8] = 8'($urandom) & mb;
      // now and then a value bit outside its mask: that pattern is dead
      if ($urandom_range(99) < 3) v[k*8 +: 8] = 8'($urandom);
    end
    r = $urandom_range(99);
    if (force_len >= 0) len = force_len;
    else if (r < 5) len = 0;
    else if (r < 10) len = $urandom_range(31, NUM_CELLS + 1);
    else if (r < 25) len = NUM_CELLS;
    else if (r < 35) len = 1;
    else len = $urandom_range(NUM_CELLS - 1, 2);
    lw = {$urandom, $urandom};   // junk above the length field
    lw[4:0] = len[4:0];
    load_pattern(v, m, lw, $urandom_range(3) == 0);
  endtask

  // Lay down one occurrence of the pattern with random wildcard bits;
  // a broken one gets a cared-about bit flipped somewhere.
  task automatic plant(input bit broken);
    int n, bad;
    bit [7:0] d, mv, vv;
    n = (sb.pat_len >= 1 && sb.pat_len <= NUM_CELLS) ? sb.pat_len
                                                      : $urandom_range(NUM_CELLS, 1);
    bad = broken ? $urandom_range(n - 1) : -1;
    if ($urandom_range(4) == 0) restart_next = 1'b1;
    for (int k = 0; k < n; k++) begin
      mv = sb.pat_mask(k);
      vv = sb.pat_value(k);
      d = (vv & mv) | (8'($urandom) & ~mv);
      if (k == bad) d = d ^ (mv & (8'h01 << $urandom_range(7)));
      emit(d);
    end
  endtask

  task automatic run_phase(input int n_items);
    int unsigned start;
    int r;
    start = sent;
    while (sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 2) begin
        wait_drained();                       // sender holds until all results are back
      end else if (r < 60) begin
        plant(1'b0);
      end else if (r < 75) begin
        plant(1'b1);
      end else if (r < 85) begin
        // jump to a new region; without a restart the regions join
        next_addr = rand_addr();
        restart_next = 1'($urandom_range(1));
      end else begin
        repeat ($urandom_range(6, 1)) emit(8'($urandom));
      end
    end
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_VAL_LO;
    cfg_wdata_i = '0;
    item_ch.valid = 1'b0;
    item_ch.data_byte = '0;
    item_ch.byte_address = '0;
    item_ch.restart = 1'b0;
    result_ch.ready = 1'b0;
    sb = new();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the length is zero: nothing may match.
    send_byte(8'hFF, ADDR_TOP, 1'b0);
    send_byte(8'h00, '0, 1'b1);

    // Four bytes: DE exact, x-D low nibble, B-x high nibble, wild byte.
    // Spare register indexes are hit here too.
    load_pattern(128'h0000_0000_0000_0000_A5A5_A5A5_00B0_0DDE,
                 128'h0000_0000_0000_0000_FFFF_FFFF_00F0_0FFF, 64'd4, 1'b1);
    send_byte(8'hDE, 48'd2, 1'b1);           // window still short
    send_byte(8'h5D, 48'd3, 1'b0);
    send_byte(8'hB7, 48'd4, 1'b0);
    send_byte(8'h42, 48'd5, 1'b0);           // hit, starts at 2
    send_byte(8'hDE, ADDR_TOP - 1, 1'b1);    // span crosses the top of memory
    send_byte(8'hFD, ADDR_TOP, 1'b0);
    send_byte(8'hB9, '0, 1'b0);
    send_byte(8'hFF, 48'd1, 1'b0);           // hit, start address wraps
    send_byte(8'hDE, 48'h100, 1'b0);
    send_byte(8'h0D, 48'h101, 1'b0);
    send_byte(8'hB0, 48'h102, 1'b1);         // restart splits the span
    send_byte(8'h00, 48'h103, 1'b0);

    // Value bit outside its mask: dead pattern.
    load_pattern(128'h1F, 128'h0F, 64'd1, 1'b0);
    send_byte(8'h1F, 48'd7, 1'b0);
    send_byte(8'h0F, 48'd8, 1'b0);

    // Single fully wild byte: every transfer hits at its own address.
    load_pattern('0, '0, 64'd1, 1'b0);
    send_byte(8'h00, '0, 1'b0);
    send_byte(8'hFF, ADDR_TOP, 1'b1);

    // Length past the window depth never hits, junk in the upper word bits.
    load_pattern('0, '0, 64'hFFFF_FFFF_FFFF_FFE0 | 64'(NUM_CELLS + 1), 1'b0);
    send_byte(8'hA5, 48'h5555_5555_5555, 1'b0);
    send_byte(8'h5A, 48'hAAAA_AAAA_AAAA, 1'b0);

    // Random part. Extreme settings first, then random ones; one phase runs
    // with no idling on either side.
    load_pattern('1, '1, 64'(NUM_CELLS), 1'b0);
    next_addr = rand_addr();
    run_phase(70);
    load_pattern('0, '0, 64'(NUM_CELLS), 1'b0);
    run_phase(70);
    random_pattern(31);
    run_phase(70);
    for (int p = 0; p < 7; p++) begin
      random_pattern(-1);
      steady = (p == 0);
      run_phase(steady ? 150 : 70);
    end
    steady = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("results still outstanding at end");

    $display("Scanned %0d bytes (%0d with restart) under %0d pattern settings;",
             sent, restarts, settings);
    $display("%0d pattern hits seen, %0d errors.", sb.hits, sb.errors);
    if (sb.errors == 0) begin
      $display("masked_byte_pattern_scanner_core: match");
    end else begin
      $display("masked_byte_pattern_scanner_core: mismatch");
    end
    $finish;
  end

endmodule
